FILE: rtl/core/tbpd_pkg.sv
// shared types and codes for the two-beam pass detector
package tbpd_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // phase codes
  localparam logic [1:0] PH_WAIT_A  = 2'd0;
  localparam logic [1:0] PH_WAIT_B  = 2'd1;
  localparam logic [1:0] PH_LOCKOUT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 2'd2;

  // register reset values
  localparam logic [TIME_W-1:0] MIN_GAP_RST = 32'd20;
  localparam logic [TIME_W-1:0] MAX_GAP_RST = 32'd2000;
  localparam logic [TIME_W-1:0] LOCKOUT_RST = 32'd300;

  typedef struct packed {
    logic [TIME_W-1:0] min_gap_ms;
    logic [TIME_W-1:0] max_gap_ms;
    logic [TIME_W-1:0] lockout_ms;
  } cfg_t;

  typedef struct packed {
    logic              beam_a;
    logic              beam_b;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [TIME_W-1:0] a_block_time;
    logic [TIME_W-1:0] lock_start_time;
  } state_t;

endpackage

FILE: rtl/core/tbpd_if.sv
// channel interfaces: sample requests, result requests, register writes
interface tbpd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        beam_a;
  logic                        beam_b;
  logic [tbpd_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output beam_a, output beam_b, output now_ms, input ready);
  modport sink   (input valid, input beam_a, input beam_b, input now_ms, output ready);
endinterface

interface tbpd_out_if;
  logic valid;
  logic ready;
  logic pass_counted;

  modport source (output valid, output pass_counted, input ready);
  modport sink   (input valid, input pass_counted, output ready);
endinterface

interface tbpd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tbpd_pkg::CFG_IDX_W-1:0] index;
  logic [tbpd_pkg::TIME_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/two_beam_pass_detector.sv
// top level of the two-beam pass detector
// path: an accepted sample request is held in the input register, then its result is
//   registered in the output register, from which the result request is taken
// throughput: one sample per cycle unless the output stalls; the state registers close
//   a loop through the step logic, so each sample sees the state the previous one left
// reset: synchronous active-low rst_n clears phase to wait for a, both times to
//   zero, the pipeline valids, and loads the register defaults 20, 2000, 300
module two_beam_pass_detector (
  input logic        clk,
  input logic        rst_n,
  tbpd_in_if.sink    in_ch,
  tbpd_out_if.source out_ch,
  tbpd_cfg_if.sink   cfg_ch
);

  // register bank, writes always taken
  tbpd_pkg::cfg_t cfg;

  assign cfg_ch.ready = 1'b1;

  tbpd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // input register
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  tbpd_pkg::sample_t s1_smp_r;
  logic              in_take;

  // output register
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_pass_r;

  // detector state
  tbpd_pkg::state_t  state_r;
  tbpd_pkg::state_t  state_nxt;
  tbpd_pkg::state_t  step_state;
  logic              step_hit;

  // the staged sample moves on when the output slot is free or being drained
  logic              advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  tbpd_step u_step (
    .cfg       (cfg),
    .state     (state_r),
    .smp       (s1_smp_r),
    .state_nxt (step_state),
    .hit       (step_hit)
  );

  // state only commits when the sample really leaves the input register
  assign state_nxt = advance ? step_state : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r              <= 1'b0;
      out_valid_r             <= 1'b0;
      state_r.phase           <= tbpd_pkg::PH_WAIT_A;
      state_r.a_block_time    <= '0;
      state_r.lock_start_time <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_smp_r.beam_a <= in_ch.beam_a;
      s1_smp_r.beam_b <= in_ch.beam_b;
      s1_smp_r.now_ms <= in_ch.now_ms;
    end
    if (advance) begin
      out_pass_r <= step_hit;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pass_counted = out_pass_r;

  // a counted pass always enters lockout stamped with that sample's time
  a_hit_locks: assert property (@(posedge clk) disable iff (!rst_n)
    advance && step_hit |=> (state_r.phase == tbpd_pkg::PH_LOCKOUT) &&
                            (state_r.lock_start_time == $past(s1_smp_r.now_ms)))
    else $error("pass did not enter lockout");

  // a pass needs both beams blocked in the sample
  a_hit_beams: assert property (@(posedge clk) disable iff (!rst_n)
    advance && step_hit |-> s1_smp_r.beam_a && s1_smp_r.beam_b)
    else $error("pass counted without both beams blocked");

  // state never moves without a sample leaving the input register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("state changed with no sample consumed");

  // a stalled staged sample is not dropped
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_smp_r))
    else $error("staged sample lost while stalled");

endmodule

FILE: rtl/core/tbpd_cfg.sv
// configuration register bank
module tbpd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tbpd_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [tbpd_pkg::TIME_W-1:0]    wr_data,
  output tbpd_pkg::cfg_t                 cfg
);

  tbpd_pkg::cfg_t cfg_r;
  tbpd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        tbpd_pkg::CFG_MIN_GAP: cfg_nxt.min_gap_ms = wr_data;
        tbpd_pkg::CFG_MAX_GAP: cfg_nxt.max_gap_ms = wr_data;
        tbpd_pkg::CFG_LOCKOUT: cfg_nxt.lockout_ms = wr_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gap_ms <= tbpd_pkg::MIN_GAP_RST;
      cfg_r.max_gap_ms <= tbpd_pkg::MAX_GAP_RST;
      cfg_r.lockout_ms <= tbpd_pkg::LOCKOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/tbpd_step.sv
// next-state and pass decision for one beam sample
module tbpd_step (
  input  tbpd_pkg::cfg_t    cfg,
  input  tbpd_pkg::state_t  state,
  input  tbpd_pkg::sample_t smp,
  output tbpd_pkg::state_t  state_nxt,
  output logic              hit
);

  logic [tbpd_pkg::TIME_W-1:0] lock_elapsed;
  logic [tbpd_pkg::TIME_W-1:0] gap;
  logic                        lock_run;
  logic [1:0]                  eff_phase;

  assign lock_elapsed = smp.now_ms - state.lock_start_time;
  assign gap          = smp.now_ms - state.a_block_time;
  assign lock_run     = (state.phase == tbpd_pkg::PH_LOCKOUT) &&
                        (lock_elapsed < cfg.lockout_ms);
  // expired lockout falls through as wait for a
  assign eff_phase    = (state.phase == tbpd_pkg::PH_LOCKOUT) ? tbpd_pkg::PH_WAIT_A
                                                              : state.phase;

  always_comb begin
    state_nxt = state;
    hit       = 1'b0;
    if (!lock_run) begin
      case (eff_phase)
        tbpd_pkg::PH_WAIT_B: begin
          if (smp.beam_b) begin
            if (smp.beam_a && (gap >= cfg.min_gap_ms) && (gap <= cfg.max_gap_ms)) begin
              state_nxt.phase           = tbpd_pkg::PH_LOCKOUT;
              state_nxt.lock_start_time = smp.now_ms;
              hit                       = 1'b1;
            end else if (gap > cfg.max_gap_ms) begin
              state_nxt.phase = tbpd_pkg::PH_WAIT_A;
            end
          end else if (!smp.beam_a) begin
            state_nxt.phase = tbpd_pkg::PH_WAIT_A;
          end
        end
        default: begin
          // wait for a, also the unused code
          state_nxt.phase = tbpd_pkg::PH_WAIT_A;
          if (smp.beam_a && !smp.beam_b) begin
            state_nxt.a_block_time = smp.now_ms;
            state_nxt.phase        = tbpd_pkg::PH_WAIT_B;
          end
        end
      endcase
    end
  end

endmodule
